/* src/lerp_pkg.sv */
// shared constants and types for the two point linear interpolation block
package lerp_pkg;

  localparam int DATA_W    = 32;
  localparam int DIV_STEPS = DATA_W;
  localparam int IN_W      = 5 * DATA_W;

  localparam logic [DATA_W-1:0] SAT_RESULT = 32'h7FFF_FFFF;

  typedef struct packed {
    logic [DATA_W-1:0] num;
    logic [DATA_W-1:0] span;
    logic [DATA_W-1:0] ay;
  } front_out_t;

  typedef struct packed {
    logic [DATA_W-1:0] ay;
    logic              neg;
    logic              num_zero;
    logic              span_zero;
  } div_side_t;

endpackage

/* src/two_point_linear_interpolation.sv */
// top level of the two point linear interpolation block
//
// input stream s_*: one word per query, five signed 32-bit fields
// (point_a_x, point_b_x, point_a_y, point_b_y, query_x), accepted when
// s_tvalid and s_tready are both high.
// output stream m_*: one word per query holding the signed 32-bit
// interpolated_y, delivered in input order.
// the line is evaluated as point_a_y + round(dy * dx / span); a zero
// numerator gives point_a_y, otherwise a zero span gives 0x7fffffff.
// from accept to m_tvalid a word passes three front stages
// (differences, 32x32 product, rounding add), one sign and magnitude
// stage, 32 divider stages of one quotient bit each, and the output
// register. throughput is one word per cycle unless m_tready stalls.
// each stage advances when it is empty or the stage after it advances,
// so bubbles close up and s_tready only drops once every stage is full
// behind a stalled m_tready; nothing is lost or repeated.
// rst (synchronous, active high) empties every stage; no words are
// pending afterwards.
module two_point_linear_interpolation (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // point_a_x, point_b_x, point_a_y, point_b_y, query_x
  input  logic [lerp_pkg::IN_W-1:0]     s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // interpolated_y
  output logic [lerp_pkg::DATA_W-1:0]   m_tdata
);

  localparam int W = lerp_pkg::DATA_W;

  logic                 front_valid, front_ready;
  lerp_pkg::front_out_t front_data;
  logic                 div_valid, div_ready;
  logic [W-1:0]         div_quot;
  lerp_pkg::div_side_t  div_side;

  logic         en_out;
  logic [W-1:0] quot_s;
  logic [W-1:0] res;

  lerp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .point_a_x (s_tdata[W-1:0]),
    .point_b_x (s_tdata[2*W-1:W]),
    .point_a_y (s_tdata[3*W-1:2*W]),
    .point_b_y (s_tdata[4*W-1:3*W]),
    .query_x   (s_tdata[5*W-1:4*W]),
    .out_valid (front_valid),
    .out_ready (front_ready),
    .out_data  (front_data)
  );

  lerp_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_data   (front_data),
    .out_valid (div_valid),
    .out_ready (div_ready),
    .out_quot  (div_quot),
    .out_side  (div_side)
  );

  assign en_out    = ~m_tvalid | m_tready;
  assign div_ready = en_out;

  always_comb begin
    quot_s = div_side.neg ? W'(0 - div_quot) : div_quot;
    if (div_side.num_zero) begin
      res = div_side.ay;
    end else if (div_side.span_zero) begin
      res = lerp_pkg::SAT_RESULT;
    end else begin
      res = quot_s + div_side.ay;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en_out) begin
      m_tvalid <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      m_tdata <= res;
    end
  end

endmodule

/* src/lerp_front.sv */
// front pipeline: differences, product and rounding add in three stages
module lerp_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [31:0]       point_a_x,
  input  logic signed [31:0]       point_b_x,
  input  logic signed [31:0]       point_a_y,
  input  logic signed [31:0]       point_b_y,
  input  logic signed [31:0]       query_x,
  output logic                     out_valid,
  input  logic                     out_ready,
  output lerp_pkg::front_out_t     out_data
);

  logic v1, v2, v3;
  logic en1, en2, en3;

  logic [lerp_pkg::DATA_W-1:0] dx1, dy1, span1, ay1;
  logic [lerp_pkg::DATA_W-1:0] prod2, span2, ay2;
  logic [lerp_pkg::DATA_W-1:0] num3, span3, ay3;

  logic                          gt;
  logic [lerp_pkg::DATA_W-1:0]   dx_c, span_c;
  logic [lerp_pkg::DATA_W-1:0]   prod_full;

  assign en3      = ~v3 | out_ready;
  assign en2      = ~v2 | en3;
  assign en1      = ~v1 | en2;
  assign in_ready = en1;

  // reversed form when the first point lies to the right
  always_comb begin
    gt = point_a_x > point_b_x;
    if (gt) begin
      span_c = 32'(point_a_x - point_b_x);
      dx_c   = 32'(point_a_x - query_x);
    end else begin
      span_c = 32'(point_b_x - point_a_x);
      dx_c   = 32'(query_x - point_a_x);
    end
  end

  assign prod_full = dy1 * dx1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      dx1   <= dx_c;
      dy1   <= 32'(point_b_y - point_a_y);
      span1 <= span_c;
      ay1   <= point_a_y;
    end
    if (en2) begin
      prod2 <= prod_full;
      span2 <= span1;
      ay2   <= ay1;
    end
    if (en3) begin
      num3  <= prod2 + {span2[lerp_pkg::DATA_W-1], span2[lerp_pkg::DATA_W-1:1]};
      span3 <= span2;
      ay3   <= ay2;
    end
  end

  assign out_valid     = v3;
  assign out_data.num  = num3;
  assign out_data.span = span3;
  assign out_data.ay   = ay3;

endmodule

/* src/lerp_div.sv */
// pipelined restoring divider, one quotient bit per stage, magnitudes and flags in front
module lerp_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  lerp_pkg::front_out_t          in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lerp_pkg::DATA_W-1:0]   out_quot,
  output lerp_pkg::div_side_t           out_side
);

  localparam int N = lerp_pkg::DIV_STEPS;
  localparam int W = lerp_pkg::DATA_W;

  logic                v  [0:N];
  logic                en [0:N];
  logic [W-1:0]        rem [0:N];
  logic [W-1:0]        nq  [0:N];
  logic [W-1:0]        dm  [0:N];
  lerp_pkg::div_side_t side [0:N];

  logic nneg, dneg;

  assign nneg = in_data.num[W-1];
  assign dneg = in_data.span[W-1];

  assign en[N]    = ~v[N] | out_ready;
  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en[0]) begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      rem[0]            <= '0;
      nq[0]             <= nneg ? W'(0 - in_data.num) : in_data.num;
      dm[0]             <= dneg ? W'(0 - in_data.span) : in_data.span;
      side[0].ay        <= in_data.ay;
      side[0].neg       <= nneg ^ dneg;
      side[0].num_zero  <= in_data.num == '0;
      side[0].span_zero <= in_data.span == '0;
    end
  end

  genvar k;
  generate
    for (k = 1; k <= N; k++) begin : g_step
      logic [W:0] sh;
      logic [W:0] diff;

      if (k < N) begin : g_en
        assign en[k] = ~v[k] | en[k+1];
      end

      assign sh   = {rem[k-1], nq[k-1][W-1]};
      assign diff = sh - {1'b0, dm[k-1]};

      always_ff @(posedge clk) begin
        if (rst) begin
          v[k] <= 1'b0;
        end else if (en[k]) begin
          v[k] <= v[k-1];
        end
      end

      always_ff @(posedge clk) begin
        if (en[k]) begin
          if (!diff[W]) begin
            rem[k] <= diff[W-1:0];
            nq[k]  <= {nq[k-1][W-2:0], 1'b1};
          end else begin
            rem[k] <= sh[W-1:0];
            nq[k]  <= {nq[k-1][W-2:0], 1'b0};
          end
          dm[k]   <= dm[k-1];
          side[k] <= side[k-1];
        end
      end
    end
  endgenerate

  assign en[0] = ~v[0] | en[1];

  assign out_valid = v[N];
  assign out_quot  = nq[N];
  assign out_side  = side[N];

endmodule

/* src/lerp_checker.sv */
// port level checks for the two point linear interpolation block
module lerp_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("output word changed while stalled");

  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input refused without an output stall");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

  a_input_seen: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && !s_tready |-> m_tvalid)
    else $error("input stalled with empty output");

endmodule

bind two_point_linear_interpolation lerp_checker u_lerp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

/* test/tb.sv */
// self-checking testbench for the two point linear interpolation block
`timescale 1ns / 1ps

module tb;

  localparam int DATA_W = lerp_pkg::DATA_W;
  localparam int IN_W   = lerp_pkg::IN_W;

  localparam int N_RANDOM  = 1428;
  localparam int PHASE_LEN = N_RANDOM / 4;
  localparam int HOLD_AT   = 60;
  localparam int HOLD_LEN  = 400;
  localparam int DRAIN     = 60;
  localparam int LIMIT     = 200_000;

  localparam logic [DATA_W-1:0] SAT_RESULT = lerp_pkg::SAT_RESULT;
  localparam logic [DATA_W-1:0] S32_MIN = 32'h8000_0000;
  localparam logic [DATA_W-1:0] S32_MAX = 32'h7FFF_FFFF;

  // point_a_x sits in the lowest bits of the word
  typedef struct packed {
    logic [DATA_W-1:0] query_x;
    logic [DATA_W-1:0] point_b_y;
    logic [DATA_W-1:0] point_a_y;
    logic [DATA_W-1:0] point_b_x;
    logic [DATA_W-1:0] point_a_x;
  } query_t;

  typedef struct packed {
    logic              typed;
    logic [DATA_W-1:0] y;
    query_t            q;
  } curve_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [DATA_W-1:0] m_tdata;

  logic [DATA_W-1:0] expected_y_q[$];
  logic [DATA_W-1:0] want_y;
  int                fail_count = 0;
  int                cycle_count = 0;
  int                tx_idle_pct = 0;
  int                rx_stall_pct = 0;
  logic              hold_go = 1'b0;
  logic              hold_active = 1'b0;

  // qx, by, ay, bx, ax
  curve_row_t curve_rows [22] = '{
    '{1'b1, 32'd0,        '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0}},
    '{1'b1, S32_MAX,      '{32'd3, 32'd9, 32'd5, 32'd0, 32'd0}},
    '{1'b1, -32'sd42,     '{32'd1234, -32'sd42, -32'sd42, 32'd7, 32'd7}},
    '{1'b1, 32'd50,       '{32'd5, 32'd100, 32'd0, 32'd10, 32'd0}},
    '{1'b0, 32'd0,        '{32'd5, 32'd0, 32'd100, 32'd0, 32'd10}},
    '{1'b1, 32'd1,        '{32'd1, 32'd0, 32'd1, 32'd2, 32'd0}},
    '{1'b0, 32'd0,        '{32'd0, 32'd1, 32'd0, S32_MAX, S32_MIN}},
    '{1'b0, 32'd0,        '{32'd1, 32'd1, 32'd0, S32_MAX, S32_MIN}},
    '{1'b1, S32_MAX,      '{S32_MAX, S32_MAX, S32_MAX, S32_MAX, S32_MAX}},
    '{1'b1, S32_MIN,      '{S32_MIN, S32_MIN, S32_MIN, S32_MIN, S32_MIN}},
    '{1'b1, 32'hFFFF_FFFF, '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                             32'hFFFF_FFFF, 32'hFFFF_FFFF}},
    '{1'b0, 32'd0,        '{S32_MIN, S32_MAX, S32_MIN, S32_MAX, S32_MIN}},
    '{1'b0, 32'd0,        '{S32_MAX, S32_MIN, S32_MAX, S32_MIN, S32_MAX}},
    '{1'b0, 32'd0,        '{32'd0, 32'd20, 32'd10, -32'sd1, 32'd1}},
    '{1'b0, 32'd0,        '{32'd0, 32'd20, 32'd10, 32'd1, -32'sd1}},
    '{1'b0, 32'd0,        '{32'd25, 32'd100, 32'd0, 32'd10, 32'd0}},
    '{1'b0, 32'd0,        '{32'd1, -32'sd10, 32'd0, 32'd3, 32'd0}},
    '{1'b1, S32_MAX,      '{-32'sd7, S32_MIN, S32_MAX, -32'sd3, -32'sd3}},
    '{1'b0, 32'd0,        '{32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                            32'h5555_5555, 32'hAAAA_AAAA}},
    '{1'b0, 32'd0,        '{32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                            32'hAAAA_AAAA, 32'h5555_5555}},
    '{1'b0, 32'd0,        '{32'd65536, 32'd65536, 32'd0, 32'd0, 32'd0}},
    '{1'b0, 32'd0,        '{32'd100, 32'd5, -32'sd5, 32'd200, 32'd100}}
  };

  two_point_linear_interpolation dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
  end

  function automatic logic [DATA_W-1:0] interp_predict(input query_t q);
    logic [DATA_W-1:0] dy, dx, span, num, num_mag, span_mag, quo;
    dy = q.point_b_y - q.point_a_y;
    if ($signed(q.point_a_x) > $signed(q.point_b_x)) begin
      span = q.point_a_x - q.point_b_x;
      dx   = q.point_a_x - q.query_x;
    end else begin
      span = q.point_b_x - q.point_a_x;
      dx   = q.query_x - q.point_a_x;
    end
    num = dy * dx + {span[DATA_W-1], span[DATA_W-1:1]};
    if (num == '0) return q.point_a_y;
    if (span == '0) return SAT_RESULT;
    num_mag  = num[DATA_W-1] ? -num : num;
    span_mag = span[DATA_W-1] ? -span : span;
    quo = num_mag / span_mag;
    if (num[DATA_W-1] != span[DATA_W-1]) quo = -quo;
    return quo + q.point_a_y;
  endfunction

  function automatic logic [DATA_W-1:0] corner_word();
    case ($urandom_range(0, 5))
      0: return S32_MIN;
      1: return S32_MAX;
      2: return '0;
      3: return 32'd1;
      4: return '1;
      default: return $urandom();
    endcase
  endfunction

  function automatic query_t gen_query();
    query_t q;
    q.point_a_x = $urandom();
    q.point_b_x = $urandom();
    q.point_a_y = $urandom();
    q.point_b_y = $urandom();
    q.query_x   = $urandom();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        // sensor-like curve: small coordinates, query near the segment
        q.point_a_x = $urandom_range(0, 2000) - 1000;
        q.point_b_x = q.point_a_x + $urandom_range(0, 400) - 200;
        q.query_x   = q.point_a_x + $urandom_range(0, 1200) - 600;
        q.point_a_y = $urandom_range(0, 200000) - 100000;
        q.point_b_y = $urandom_range(0, 200000) - 100000;
      end
      6: q.point_b_x = q.point_a_x;
      7: begin
        if ($urandom_range(0, 1) == 0) q.point_b_y = q.point_a_y;
        else q.query_x = q.point_a_x;
      end
      8: begin
        q.point_a_x = corner_word();
        q.point_b_x = corner_word();
        q.point_a_y = corner_word();
        q.point_b_y = corner_word();
        q.query_x   = corner_word();
      end
      9: begin
        q.point_a_x = corner_word();
        q.point_b_x = corner_word();
      end
      default: ;
    endcase
    return q;
  endfunction

  task automatic send_query(input query_t q, input logic typed, input logic [DATA_W-1:0] y);
    while (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tdata  <= q;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    expected_y_q.push_back(typed ? y : interp_predict(q));
  endtask

  initial begin
    do @(posedge clk); while (rst);
    foreach (curve_rows[i])
      send_query(curve_rows[i].q, curve_rows[i].typed, curve_rows[i].y);
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % PHASE_LEN == 0) begin
        case (i / PHASE_LEN)
          0: begin tx_idle_pct = 0;  rx_stall_pct <= 0;  end
          1: begin tx_idle_pct = 69; rx_stall_pct <= 0;  end
          2: begin tx_idle_pct = 0;  rx_stall_pct <= 69; end
          default: begin tx_idle_pct = 17; rx_stall_pct <= 17; end
        endcase
      end
      if (i == HOLD_AT) hold_go <= 1'b1;
      send_query(gen_query(), 1'b0, '0);
    end
    s_tvalid <= 1'b0;
    while (expected_y_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (fail_count == 0)
      $display("two_point_linear_interpolation regression: pass");
    else
      $display("two_point_linear_interpolation regression: fail");
    $finish;
  end

  // long receiver hold-off so the pipeline backs up into s_tready
  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_active <= 1'b1;
    repeat (HOLD_LEN) @(posedge clk);
    hold_active <= 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_y_q.size() == 0) begin
          $error("interpolated_y: expected no word, got %0d", $signed(m_tdata));
          fail_count++;
        end else begin
          want_y = expected_y_q.pop_front();
          if (m_tdata !== want_y) begin
            $error("interpolated_y: expected %0d, got %0d", $signed(want_y),
                   $signed(m_tdata));
            fail_count++;
          end
        end
      end
      m_tready <= !hold_active &&
                  !(rx_stall_pct > 0 && $urandom_range(0, 99) < rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT) begin
      $display("two_point_linear_interpolation regression: fail");
      $finish;
    end
  end

endmodule
